// ----- src/aes_block_encrypt_assert.svh -----
// Assertion macros for the block encrypt core
`ifndef AES_BLOCK_ENCRYPT_ASSERT_SVH
`define AES_BLOCK_ENCRYPT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define AESBE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("aesbe: same-cycle check failed");
// next-cycle implication
`define AESBE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("aesbe: next-cycle check failed");
`else
`define AESBE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define AESBE_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- src/aesbe_pkg.sv -----
`default_nettype none
package aesbe_pkg;

    // key length codes
    localparam logic [1:0] MODE_128 = 2'd0;
    localparam logic [1:0] MODE_192 = 2'd1;
    localparam logic [1:0] MODE_256 = 2'd2;

    // register indexes
    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_KEY0 = 3'd1;
    localparam logic [2:0] REG_KEY1 = 3'd2;
    localparam logic [2:0] REG_KEY2 = 3'd3;
    localparam logic [2:0] REG_KEY3 = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    // key expander control
    typedef struct packed {
        logic       load;
        logic       step;
        logic [1:0] mode;
    } t_kctl;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] sbox(input logic [7:0] x);
        return SBOX[x];
    endfunction

    // multiply by x in GF(2^8)
    function automatic logic [7:0] gf_dbl(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

endpackage
`default_nettype wire

// ----- src/aesbe_round.sv -----
`default_nettype none
module aesbe_round (
    input  wire logic [127:0] i_state,
    input  wire logic [127:0] i_rk,
    input  wire logic         i_first,
    input  wire logic         i_last,
    output logic      [127:0] o_state
);
    import aesbe_pkg::*;

    logic [7:0] b_in  [16];
    logic [7:0] b_sub [16];
    logic [7:0] b_sr  [16];
    logic [7:0] b_mix [16];
    logic [127:0] w_rnd;

    // SubBytes and ShiftRows; byte i sits in row i mod 4, column i / 4
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            b_in[i]  = i_state[127 - 8*i -: 8];
            b_sub[i] = sbox(b_in[i]);
        end
        for (int row = 0; row < 4; row++) begin
            for (int col = 0; col < 4; col++) begin
                b_sr[row + 4*col] = b_sub[row + 4*((col + row) % 4)];
            end
        end
    end

    // MixColumns, skipped in the last round
    always_comb begin
        logic [7:0] s;
        for (int c = 0; c < 4; c++) begin
            s = b_sr[4*c] ^ b_sr[4*c+1] ^ b_sr[4*c+2] ^ b_sr[4*c+3];
            if (i_last) begin
                b_mix[4*c]   = b_sr[4*c];
                b_mix[4*c+1] = b_sr[4*c+1];
                b_mix[4*c+2] = b_sr[4*c+2];
                b_mix[4*c+3] = b_sr[4*c+3];
            end else begin
                b_mix[4*c]   = b_sr[4*c]   ^ s ^ gf_dbl(b_sr[4*c]   ^ b_sr[4*c+1]);
                b_mix[4*c+1] = b_sr[4*c+1] ^ s ^ gf_dbl(b_sr[4*c+1] ^ b_sr[4*c+2]);
                b_mix[4*c+2] = b_sr[4*c+2] ^ s ^ gf_dbl(b_sr[4*c+2] ^ b_sr[4*c+3]);
                b_mix[4*c+3] = b_sr[4*c+3] ^ s ^ gf_dbl(b_sr[4*c+3] ^ b_sr[4*c]);
            end
        end
        for (int i = 0; i < 16; i++) begin
            w_rnd[127 - 8*i -: 8] = b_mix[i];
        end
    end

    // add round key; the initial pass is the key add alone
    assign o_state = (i_first ? i_state : w_rnd) ^ i_rk;

endmodule
`default_nettype wire

// ----- src/aesbe_keyexp.sv -----
`default_nettype none
module aesbe_keyexp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire aesbe_pkg::t_kctl  i_ctl,
    input  wire logic [255:0]      i_key,
    output logic      [127:0]      o_rk
);
    import aesbe_pkg::*;

    // window of the eight newest schedule words, r_win[7] newest
    logic [31:0] r_win [8];
    logic [2:0]  r_pos;
    logic [7:0]  r_rc;

    logic [31:0] kw   [8];
    logic [31:0] old  [4];
    logic [31:0] nw   [4];
    logic [2:0]  nkw_m1;
    logic [2:0]  n_pos;
    logic        w_hit;

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            kw[j] = i_key[255 - 32*j -: 32];
        end
    end

    // words i - nkw and the round key, by key length
    always_comb begin
        case (i_ctl.mode)
            MODE_128: begin
                nkw_m1 = 3'd3;
                for (int k = 0; k < 4; k++) old[k] = r_win[4 + k];
                o_rk = {r_win[4], r_win[5], r_win[6], r_win[7]};
            end
            MODE_192: begin
                nkw_m1 = 3'd5;
                for (int k = 0; k < 4; k++) old[k] = r_win[2 + k];
                o_rk = {r_win[2], r_win[3], r_win[4], r_win[5]};
            end
            default: begin
                nkw_m1 = 3'd7;
                for (int k = 0; k < 4; k++) old[k] = r_win[k];
                o_rk = {r_win[0], r_win[1], r_win[2], r_win[3]};
            end
        endcase
    end

    // four new words per step
    always_comb begin
        logic [2:0]  p;
        logic [31:0] prev;
        logic [31:0] t;
        p     = r_pos;
        w_hit = 1'b0;
        for (int k = 0; k < 4; k++) begin
            prev = (k == 0) ? r_win[7] : nw[(k == 0) ? 0 : k - 1];
            t    = prev;
            if (p == 3'd0) begin
                t = sub_word({prev[23:0], prev[31:24]}) ^ {r_rc, 24'h0};
                w_hit = 1'b1;
            end else if (nkw_m1 == 3'd7 && p == 3'd4) begin
                t = sub_word(prev);
            end
            nw[k] = old[k] ^ t;
            p = (p == nkw_m1) ? 3'd0 : p + 3'd1;
        end
        n_pos = p;
    end

    // key load fills the top of the window, older slots cleared
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            case (i_ctl.mode)
                MODE_128: begin
                    for (int j = 0; j < 4; j++) begin
                        r_win[j]     <= '0;
                        r_win[4 + j] <= kw[j];
                    end
                end
                MODE_192: begin
                    r_win[0] <= '0;
                    r_win[1] <= '0;
                    for (int j = 0; j < 6; j++) r_win[2 + j] <= kw[j];
                end
                default: begin
                    for (int j = 0; j < 8; j++) r_win[j] <= kw[j];
                end
            endcase
        end else if (i_ctl.step) begin
            for (int j = 0; j < 4; j++) begin
                r_win[j]     <= r_win[4 + j];
                r_win[4 + j] <= nw[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_rc  <= 8'h01;
        end else if (i_ctl.load) begin
            r_pos <= '0;
            r_rc  <= 8'h01;
        end else if (i_ctl.step) begin
            r_pos <= n_pos;
            if (w_hit) r_rc <= gf_dbl(r_rc);
        end
    end

endmodule
`default_nettype wire

// ----- src/aes_block_encrypt.sv -----
// A word is taken in IDLE, then the initial key add and the rounds for
// 128-, 192- or 256-bit keys run one per cycle.
// The result word is held until taken; the next word is taken only after
// that, as one block at a time uses the shared round unit and 4-word key expander.
// Reset (synchronous, active low) clears control and config to zero.
`default_nettype none
module aes_block_encrypt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [63:0] i_plain_upper,
    input  wire logic [63:0] i_plain_lower,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic      [63:0] o_cipher_upper,
    output logic      [63:0] o_cipher_lower
);
    import aesbe_pkg::*;
    `include "aes_block_encrypt_assert.svh"

    logic [1:0]   r_mode;
    logic [63:0]  r_key [4];
    t_state       r_state, n_state;
    logic [3:0]   r_round;
    logic [127:0] r_data;
    logic [127:0] w_rnd_out;
    logic [127:0] w_rk;
    logic [3:0]   w_nr;
    logic         w_in_acc;
    logic         w_out_acc;
    logic         w_wr;
    t_kctl        w_kctl;

    assign pready    = 1'b1;
    assign w_wr      = psel && penable && pwrite;
    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_128;
            for (int j = 0; j < 4; j++) r_key[j] <= '0;
        end else if (w_wr) begin
            case (paddr[5:3])
                REG_MODE: r_mode   <= pwdata[1:0];
                REG_KEY0: r_key[0] <= pwdata;
                REG_KEY1: r_key[1] <= pwdata;
                REG_KEY2: r_key[2] <= pwdata;
                REG_KEY3: r_key[3] <= pwdata;
                default:  ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (paddr[5:3])
            REG_MODE: prdata = {62'h0, r_mode};
            REG_KEY0: prdata = r_key[0];
            REG_KEY1: prdata = r_key[1];
            REG_KEY2: prdata = r_key[2];
            REG_KEY3: prdata = r_key[3];
            default:  prdata = '0;
        endcase
    end

    // round count by key length
    always_comb begin
        case (r_mode)
            MODE_128: w_nr = 4'd10;
            MODE_192: w_nr = 4'd12;
            default:  w_nr = 4'd14;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_in_acc) n_state = S_RUN;
            S_RUN:   if (r_round == w_nr) n_state = S_DONE;
            S_DONE:  if (w_out_acc) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        o_out_valid = (r_state == S_DONE);
        w_kctl.load = (r_state == S_IDLE) && i_in_valid;
        w_kctl.step = (r_state == S_RUN);
        w_kctl.mode = r_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) r_round <= '0;
            else if (r_state == S_RUN) r_round <= r_round + 4'd1;
        end
    end

    // data word: plaintext on load, one round per cycle after
    always_ff @(posedge i_clk) begin
        if (w_in_acc) r_data <= {i_plain_upper, i_plain_lower};
        else if (r_state == S_RUN) r_data <= w_rnd_out;
    end

    aesbe_keyexp u_keyexp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_kctl),
        .i_key   ({r_key[0], r_key[1], r_key[2], r_key[3]}),
        .o_rk    (w_rk)
    );

    aesbe_round u_round (
        .i_state (r_data),
        .i_rk    (w_rk),
        .i_first (r_round == 4'd0),
        .i_last  (r_round == w_nr),
        .o_state (w_rnd_out)
    );

    assign o_cipher_upper = r_data[127:64];
    assign o_cipher_lower = r_data[63:0];

    `AESBE_ASSERT_IMP(a_hs_excl, i_clk, i_rst_n, o_in_ready, !o_out_valid)
    `AESBE_ASSERT_NXT(a_start, i_clk, i_rst_n, w_in_acc, r_state == S_RUN && r_round == 4'd0)
    `AESBE_ASSERT_IMP(a_round_rng, i_clk, i_rst_n, r_state == S_RUN, r_round <= w_nr)
    `AESBE_ASSERT_NXT(a_finish, i_clk, i_rst_n, r_state == S_RUN && r_round == w_nr, o_out_valid)

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import aesbe_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [63:0] i_plain_upper = '0;
    logic [63:0] i_plain_lower = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [63:0] o_cipher_upper;
    logic [63:0] o_cipher_lower;

    // shadow of the key registers
    logic [1:0]   key_mode = MODE_128;
    logic [63:0]  key_copy [4] = '{default: '0};
    logic [127:0] cipher_fifo [$];
    int           mismatches = 0;
    int           cycles = 0;
    bit           no_stall = 1'b0;

    aes_block_encrypt u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_plain_upper(i_plain_upper), .i_plain_lower(i_plain_lower),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_cipher_upper(o_cipher_upper), .o_cipher_lower(o_cipher_lower)
    );

    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // forward cipher of one block under the shadow key
    function automatic logic [127:0] encipher_block(input logic [63:0] up,
                                                    input logic [63:0] lo);
        int nk, nr;
        logic [7:0] ks [240];
        logic [7:0] st [16];
        logic [7:0] t [4];
        logic [7:0] rc, h, sum, first;
        logic [127:0] res;
        rc = 8'h01;
        if (key_mode == MODE_128) begin
            nk = 4; nr = 10;
        end else if (key_mode == MODE_192) begin
            nk = 6; nr = 12;
        end else begin
            nk = 8; nr = 14;
        end
        for (int i = 0; i < 4 * nk; i++)
            ks[i] = key_copy[(i >> 3) & 3][63 - 8 * (i % 8) -: 8];
        // key expansion
        for (int i = nk; i < 4 * (nr + 1); i++) begin
            for (int j = 0; j < 4; j++) t[j] = ks[4 * (i - 1) + j];
            if (i % nk == 0) begin
                h = t[0];
                t[0] = SBOX[t[1]] ^ rc;
                t[1] = SBOX[t[2]];
                t[2] = SBOX[t[3]];
                t[3] = SBOX[h];
                rc = xtime(rc);
            end else if (nk > 6 && i % nk == 4) begin
                for (int j = 0; j < 4; j++) t[j] = SBOX[t[j]];
            end
            for (int j = 0; j < 4; j++) ks[4 * i + j] = ks[4 * (i - nk) + j] ^ t[j];
        end
        for (int i = 0; i < 8; i++) begin
            st[i] = up[63 - 8 * i -: 8];
            st[8 + i] = lo[63 - 8 * i -: 8];
        end
        for (int i = 0; i < 16; i++) st[i] ^= ks[i];
        for (int r = 1; r <= nr; r++) begin
            for (int i = 0; i < 16; i++) st[i] = SBOX[st[i]];
            // row rotation, column-major state
            h = st[1]; st[1] = st[5]; st[5] = st[9]; st[9] = st[13]; st[13] = h;
            h = st[2]; st[2] = st[10]; st[10] = h;
            h = st[6]; st[6] = st[14]; st[14] = h;
            h = st[15]; st[15] = st[11]; st[11] = st[7]; st[7] = st[3]; st[3] = h;
            if (r != nr) begin
                for (int c = 0; c < 4; c++) begin
                    sum = st[4*c] ^ st[4*c+1] ^ st[4*c+2] ^ st[4*c+3];
                    first = st[4*c];
                    st[4*c]   ^= sum ^ xtime(st[4*c] ^ st[4*c+1]);
                    st[4*c+1] ^= sum ^ xtime(st[4*c+1] ^ st[4*c+2]);
                    st[4*c+2] ^= sum ^ xtime(st[4*c+2] ^ st[4*c+3]);
                    st[4*c+3] ^= sum ^ xtime(st[4*c+3] ^ first);
                end
            end
            for (int i = 0; i < 16; i++) st[i] ^= ks[16 * r + i];
        end
        for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = st[i];
        return res;
    endfunction

    // register write: setup then access
    task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 3'b000}; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_MODE) key_mode = value[1:0];
        else if (idx <= REG_KEY3) key_copy[idx - 1] = value;
    endtask

    task automatic load_key(input logic [1:0] mode, input logic [63:0] k0,
                            input logic [63:0] k1, input logic [63:0] k2,
                            input logic [63:0] k3);
        reg_write(REG_MODE, {62'd0, mode});
        reg_write(REG_KEY0, k0);
        reg_write(REG_KEY1, k1);
        reg_write(REG_KEY2, k2);
        reg_write(REG_KEY3, k3);
    endtask

    // send one plaintext word; valid stays high after acceptance
    task automatic send_block(input logic [63:0] up, input logic [63:0] lo);
        if (!no_stall && $urandom_range(99) < 6) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_plain_upper <= up;
        i_plain_lower <= lo;
        do @(posedge i_clk); while (!o_in_ready);
        cipher_fifo.push_back(encipher_block(up, lo));
    endtask

    task automatic stop_sending();
        i_in_valid <= 1'b0;
    endtask

    // quiet point before any register change
    task automatic wait_drained();
        stop_sending();
        while (cipher_fifo.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // receiver stalls
    always @(posedge i_clk) begin
        i_out_ready <= no_stall || ($urandom_range(99) >= 6);
    end

    // result checker
    always @(posedge i_clk) begin
        logic [127:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (cipher_fifo.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %h %h", o_cipher_upper, o_cipher_lower);
            end else begin
                want = cipher_fifo.pop_front();
                if (o_cipher_upper !== want[127:64]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("cipher_upper: expected %h got %h",
                                 want[127:64], o_cipher_upper);
                end
                if (o_cipher_lower !== want[63:0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("cipher_lower: expected %h got %h",
                                 want[63:0], o_cipher_lower);
                end
            end
        end
    end

    // standard vectors, one per key length
    task automatic test_known_answer();
        load_key(MODE_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'hffffffffffffffff, 64'hffffffffffffffff);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        wait_drained();
        load_key(MODE_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'hffffffffffffffff);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        wait_drained();
        load_key(MODE_256, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h18191a1b1c1d1e1f);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        wait_drained();
    endtask

    // extreme keys and blocks, unused mode code, writes past the last register
    task automatic test_extremes();
        for (int m = 0; m < 4; m++) begin
            load_key(m[1:0], '0, '0, '0, '0);
            send_block('0, '0);
            send_block('1, '1);
            wait_drained();
            load_key(m[1:0], '1, '1, '1, '1);
            send_block('0, '0);
            send_block('1, '1);
            send_block(64'h8000000000000001, 64'h0123456789abcdef);
            wait_drained();
        end
        for (int a = REG_KEY3 + 1; a < 8; a++) reg_write(a[2:0], rand64());
        send_block(rand64(), rand64());
        wait_drained();
    endtask

    // random keys and blocks over several settings
    task automatic test_random_blocks();
        logic [1:0] m;
        for (int p = 0; p < 8; p++) begin
            m = (p < 4) ? p[1:0] : 2'($urandom_range(0, 3));
            load_key(m, rand64(), rand64(), rand64(), rand64());
            no_stall = (p == 5);
            for (int n = 0; n < 125; n++) send_block(rand64(), rand64());
            wait_drained();
            no_stall = 1'b0;
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_known_answer();
        test_extremes();
        test_random_blocks();
        wait_drained();
        if (mismatches == 0 && cipher_fifo.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+src
src/aesbe_pkg.sv
src/aesbe_round.sv
src/aesbe_keyexp.sv
src/aes_block_encrypt.sv
tb/sv/testbench.sv
